### rtl/core/iqca_pkg.sv
// ============================================================================
// iqca_pkg
// Shared types and codes for the quadtree child availability block.
// ============================================================================
package iqca_pkg;

    localparam int LEVEL_W = 5;
    localparam int COORD_W = 16;
    localparam int ADDR_W  = 9;
    localparam int BYTE_W  = 8;
    localparam int SLV_W   = 3;
    localparam int CIDX_W  = 3;
    localparam int CFG_W   = 16;
    localparam int MASK_W  = 4;

    typedef enum logic {
        OP_WRITE = 1'b0,
        OP_QUERY = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        SEL_TILE    = 2'd0,
        SEL_CONTENT = 2'd1,
        SEL_CHILD   = 2'd2
    } bitmap_sel_t;

    typedef enum logic [CIDX_W-1:0] {
        REG_SUBTREE_LEVELS   = 3'd0,
        REG_AVAILABLE_LEVELS = 3'd1,
        REG_ROOT_LEVEL       = 3'd2,
        REG_ROOT_X           = 3'd3,
        REG_ROOT_Y           = 3'd4
    } cfg_reg_t;

    // classification handed from the front part to the back part
    typedef struct packed {
        logic        is_write;
        bitmap_sel_t sel;
        logic        hit;
        logic        interior;
        logic        beyond;
    } q_ctrl_t;

endpackage

### rtl/core/implicit_quadtree_child_availability_top.sv
// ============================================================================
// implicit_quadtree_child_availability_top
// Availability bitmaps of one loaded quadtree subtree with child lookup.
//
//   channel   direction  handshake             contents
//   cfg       in         cfg_write             cfg_index, cfg_data
//   in        in         in_valid / in_stall   op, bitmap_select, byte_address,
//                                              byte_value, tile_level, tile_x, tile_y
//   out       out        out_valid / out_stall children_status, subtree_hit,
//                                              child_present, child_content
//
// one request per cycle sustained while in_stall and out_stall stay low; a result passes
// through the capture stage, queue, bitmap RAM read and output register
// after reset a clearing pass zeroes the bitmap RAMs, one byte row a cycle;
// in_stall is high meanwhile
// out_stall holds the output register; the queue of QUEUE_DEPTH entries absorbs
// the capture stage before in_stall rises
// ============================================================================
module implicit_quadtree_child_availability_top
    import iqca_pkg::*;
#(
    parameter int MAX_SUBTREE_LEVELS = 6,
    parameter int COORD_BITS         = 16,
    parameter int QUEUE_DEPTH        = 4
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_write,
    input  logic [CIDX_W-1:0]   cfg_index,
    input  logic [CFG_W-1:0]    cfg_data,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic                op,
    input  logic [1:0]          bitmap_select,
    input  logic [ADDR_W-1:0]   byte_address,
    input  logic [BYTE_W-1:0]   byte_value,
    input  logic [LEVEL_W-1:0]  tile_level,
    input  logic [COORD_W-1:0]  tile_x,
    input  logic [COORD_W-1:0]  tile_y,
    output logic                out_valid,
    input  logic                out_stall,
    output logic                children_status,
    output logic                subtree_hit,
    output logic [MASK_W-1:0]   child_present,
    output logic [MASK_W-1:0]   child_content
);

    localparam int LOC_W = $clog2(MAX_SUBTREE_LEVELS + 1);
    localparam int IDX_W = 2 * MAX_SUBTREE_LEVELS;
    localparam int Q_W   = $bits(q_ctrl_t) + ADDR_W + BYTE_W + IDX_W;

    logic              clearing;
    logic              q_full;
    logic              q_valid;
    logic              push;
    logic              pop;
    q_ctrl_t           push_ctrl;
    logic [ADDR_W-1:0] push_addr;
    logic [BYTE_W-1:0] push_val;
    logic [IDX_W-1:0]  push_pos;
    q_ctrl_t           pop_ctrl;
    logic [ADDR_W-1:0] pop_addr;
    logic [BYTE_W-1:0] pop_val;
    logic [IDX_W-1:0]  pop_pos;
    logic [Q_W-1:0]    push_data;
    logic [Q_W-1:0]    pop_data;

    iqca_front #(
        .MAX_SUBTREE_LEVELS (MAX_SUBTREE_LEVELS),
        .COORD_BITS         (COORD_BITS),
        .LOC_W              (LOC_W),
        .IDX_W              (IDX_W)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .op            (op),
        .bitmap_select (bitmap_select),
        .byte_address  (byte_address),
        .byte_value    (byte_value),
        .tile_level    (tile_level),
        .tile_x        (tile_x),
        .tile_y        (tile_y),
        .clearing      (clearing),
        .q_full        (q_full),
        .push          (push),
        .push_ctrl     (push_ctrl),
        .push_addr     (push_addr),
        .push_val      (push_val),
        .push_pos      (push_pos)
    );

    assign push_data = {push_ctrl, push_addr, push_val, push_pos};

    iqca_queue #(
        .WIDTH (Q_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (q_full),
        .pop       (pop),
        .pop_data  (pop_data),
        .valid     (q_valid)
    );

    assign {pop_ctrl, pop_addr, pop_val, pop_pos} = pop_data;

    iqca_back #(
        .MAX_SUBTREE_LEVELS (MAX_SUBTREE_LEVELS),
        .IDX_W              (IDX_W)
    ) u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .q_valid         (q_valid),
        .q_ctrl          (pop_ctrl),
        .q_addr          (pop_addr),
        .q_val           (pop_val),
        .q_pos           (pop_pos),
        .pop             (pop),
        .clearing        (clearing),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .children_status (children_status),
        .subtree_hit     (subtree_hit),
        .child_present   (child_present),
        .child_content   (child_content)
    );

endmodule

### rtl/core/iqca_ram.sv
// ============================================================================
// iqca_ram
// Generic single write port, single read port RAM with registered read data.
// ============================================================================
module iqca_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = 4
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### rtl/core/iqca_front.sv
// ============================================================================
// iqca_front
// Configuration registers, request capture and classification: subtree root,
// hit test, level class and bitmap bit position of the four children.
// ============================================================================
module iqca_front
    import iqca_pkg::*;
#(
    parameter int MAX_SUBTREE_LEVELS = 6,
    parameter int COORD_BITS         = 16,
    parameter int LOC_W              = 3,
    parameter int IDX_W              = 12
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_write,
    input  logic [CIDX_W-1:0]   cfg_index,
    input  logic [CFG_W-1:0]    cfg_data,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic                op,
    input  logic [1:0]          bitmap_select,
    input  logic [ADDR_W-1:0]   byte_address,
    input  logic [BYTE_W-1:0]   byte_value,
    input  logic [LEVEL_W-1:0]  tile_level,
    input  logic [COORD_W-1:0]  tile_x,
    input  logic [COORD_W-1:0]  tile_y,
    input  logic                clearing,
    input  logic                q_full,
    output logic                push,
    output q_ctrl_t             push_ctrl,
    output logic [ADDR_W-1:0]   push_addr,
    output logic [BYTE_W-1:0]   push_val,
    output logic [IDX_W-1:0]    push_pos
);

    typedef logic [2:0] loc_tab_t [256];
    typedef logic [IDX_W-1:0] offs_t [MAX_SUBTREE_LEVELS+1];

    function automatic loc_tab_t build_local_tab();
        loc_tab_t tab;
        int       r;
        for (int si = 0; si < 8; si++)
        begin
            for (int l = 0; l < 32; l++)
            begin
                r = l;
                for (int k = 0; k < 32; k++)
                begin
                    if (r >= si + 1)
                    begin
                        r = r - (si + 1);
                    end
                end
                tab[si*32+l] = 3'(r);
            end
        end
        return tab;
    endfunction

    function automatic offs_t build_offs();
        offs_t t;
        int    acc;
        acc = 0;
        for (int c = 0; c <= MAX_SUBTREE_LEVELS; c++)
        begin
            t[c] = IDX_W'(acc);
            acc  = acc * 4 + 1;
        end
        return t;
    endfunction

    localparam loc_tab_t LOCAL_TAB = build_local_tab();
    localparam offs_t    OFFS      = build_offs();

    // configuration
    logic [SLV_W-1:0]      subtree_levels_reg;
    logic [LEVEL_W-1:0]    avail_levels_reg;
    logic [LEVEL_W-1:0]    root_level_reg;
    logic [COORD_W-1:0]    root_x_reg;
    logic [COORD_W-1:0]    root_y_reg;

    // capture stage
    logic                  f1_valid_reg;
    logic                  f1_valid_next;
    op_t                   f1_op_reg;
    logic [1:0]            f1_sel_reg;
    logic [ADDR_W-1:0]     f1_addr_reg;
    logic [BYTE_W-1:0]     f1_val_reg;
    logic [LEVEL_W-1:0]    f1_lvl_reg;
    logic [COORD_BITS-1:0] f1_x_reg;
    logic [COORD_BITS-1:0] f1_y_reg;
    logic [LOC_W-1:0]      f1_loc_reg;

    logic                  accept;
    logic [3:0]            s_ext;
    logic [LOC_W-1:0]      s_eff;
    logic [2:0]            s_m1;
    logic [LOC_W-1:0]      loc_next;

    logic [LEVEL_W-1:0]    root_lvl;
    logic [COORD_BITS-1:0] rx;
    logic [COORD_BITS-1:0] ry;
    logic [LOC_W:0]        cloc;
    logic [31:0]           xw;
    logic [31:0]           yw;
    logic [IDX_W-1:0]      m4;
    logic                  hit;
    logic                  interior;
    logic                  beyond;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            subtree_levels_reg <= SLV_W'(1);
            avail_levels_reg   <= '0;
            root_level_reg     <= '0;
            root_x_reg         <= '0;
            root_y_reg         <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_SUBTREE_LEVELS:   subtree_levels_reg <= cfg_data[SLV_W-1:0];
                REG_AVAILABLE_LEVELS: avail_levels_reg   <= cfg_data[LEVEL_W-1:0];
                REG_ROOT_LEVEL:       root_level_reg     <= cfg_data[LEVEL_W-1:0];
                REG_ROOT_X:           root_x_reg         <= cfg_data[COORD_W-1:0];
                REG_ROOT_Y:           root_y_reg         <= cfg_data[COORD_W-1:0];
                default:              ;
            endcase
        end
    end

    // effective subtree depth and local level
    always_comb
    begin
        s_ext = {1'b0, subtree_levels_reg};
        if (s_ext == 4'd0)
        begin
            s_ext = 4'd1;
        end
        else if (32'(s_ext) > MAX_SUBTREE_LEVELS)
        begin
            s_ext = 4'(MAX_SUBTREE_LEVELS);
        end
        s_eff    = LOC_W'(s_ext);
        s_m1     = 3'(s_ext - 4'd1);
        loc_next = LOC_W'(LOCAL_TAB[{s_m1, tile_level}]);
    end

    assign in_stall = clearing || (f1_valid_reg && q_full);
    assign accept   = in_valid && !in_stall;
    assign push     = f1_valid_reg && !q_full;

    always_comb
    begin
        f1_valid_next = f1_valid_reg;
        if (accept)
        begin
            f1_valid_next = 1'b1;
        end
        else if (push)
        begin
            f1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f1_valid_reg <= 1'b0;
        end
        else
        begin
            f1_valid_reg <= f1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            f1_op_reg   <= op_t'(op);
            f1_sel_reg  <= bitmap_select;
            f1_addr_reg <= byte_address;
            f1_val_reg  <= byte_value;
            f1_lvl_reg  <= tile_level;
            f1_x_reg    <= tile_x[COORD_BITS-1:0];
            f1_y_reg    <= tile_y[COORD_BITS-1:0];
            f1_loc_reg  <= loc_next;
        end
    end

    // hit test and child bit position
    always_comb
    begin
        root_lvl = f1_lvl_reg - LEVEL_W'(f1_loc_reg);
        rx       = f1_x_reg >> f1_loc_reg;
        ry       = f1_y_reg >> f1_loc_reg;
        hit      = (root_lvl == root_level_reg) &&
                   (rx == root_x_reg[COORD_BITS-1:0]) &&
                   (ry == root_y_reg[COORD_BITS-1:0]);
        cloc     = {1'b0, f1_loc_reg} + (LOC_W+1)'(1);
        interior = cloc < {1'b0, s_eff};
        beyond   = ({1'b0, f1_lvl_reg} + (LEVEL_W+1)'(1)) >= {1'b0, avail_levels_reg};
        xw       = 32'(f1_x_reg);
        yw       = 32'(f1_y_reg);
        m4       = '0;
        for (int i = 0; i < MAX_SUBTREE_LEVELS - 1; i++)
        begin
            if (i < int'(f1_loc_reg))
            begin
                m4[2*i+2] = xw[i];
                m4[2*i+3] = yw[i];
            end
        end
    end

    assign push_ctrl.is_write = (f1_op_reg == OP_WRITE);
    assign push_ctrl.sel      = bitmap_sel_t'(f1_sel_reg);
    assign push_ctrl.hit      = hit;
    assign push_ctrl.interior = interior;
    assign push_ctrl.beyond   = beyond;
    assign push_addr          = f1_addr_reg;
    assign push_val           = f1_val_reg;
    assign push_pos           = interior ? (OFFS[cloc[LOC_W-1:0]] + m4) : m4;

endmodule

### rtl/core/iqca_queue.sv
// ============================================================================
// iqca_queue
// Short register FIFO that decouples request classification from execution.
// ============================================================================
module iqca_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             valid
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign valid    = (count_reg != '0);
    assign pop_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("queue push while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> valid)
        else $error("queue pop while empty");

endmodule

### rtl/core/iqca_back.sv
// ============================================================================
// iqca_back
// Bitmap storage and request execution: byte writes, child mask reads,
// status decision, output register; clears the bitmaps after reset.
// ============================================================================
module iqca_back
    import iqca_pkg::*;
#(
    parameter int MAX_SUBTREE_LEVELS = 6,
    parameter int IDX_W              = 12
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_valid,
    input  q_ctrl_t             q_ctrl,
    input  logic [ADDR_W-1:0]   q_addr,
    input  logic [BYTE_W-1:0]   q_val,
    input  logic [IDX_W-1:0]    q_pos,
    output logic                pop,
    output logic                clearing,
    output logic                out_valid,
    input  logic                out_stall,
    output logic                children_status,
    output logic                subtree_hit,
    output logic [MASK_W-1:0]   child_present,
    output logic [MASK_W-1:0]   child_content
);

    localparam int TILE_DEPTH  = ((1 << (2 * MAX_SUBTREE_LEVELS)) - 1) / 3;
    localparam int CHILD_DEPTH = 1 << (2 * MAX_SUBTREE_LEVELS);
    localparam int TB          = (TILE_DEPTH + 7) / 8;
    localparam int TBANK       = TB / 2 + 2;
    localparam int CB          = (CHILD_DEPTH + 7) / 8;
    localparam int CBANK       = (CB > 1) ? CB : 2;
    localparam int TB_AW       = $clog2(TBANK);
    localparam int CB_AW       = $clog2(CBANK);
    localparam int CLR_N       = (CBANK > TBANK) ? CBANK : TBANK;
    localparam int CLR_W       = $clog2(CLR_N);

    logic                 clearing_reg;
    logic                 clearing_next;
    logic [CLR_W-1:0]     clr_reg;
    logic [CLR_W-1:0]     clr_next;

    logic                 r_valid_reg;
    logic                 r_valid_next;
    q_ctrl_t              r_ctrl_reg;
    logic                 r_b0_reg;
    logic                 r_b2_reg;

    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic                 status_reg;
    logic                 hit_reg;
    logic [MASK_W-1:0]    present_reg;
    logic [MASK_W-1:0]    content_reg;
    logic                 status_next;
    logic                 hit_next;
    logic [MASK_W-1:0]    present_next;
    logic [MASK_W-1:0]    content_next;

    logic                 out_free;
    logic                 wr;
    logic                 rd;
    logic [31:0]          qa;
    logic [31:0]          pw;
    logic [31:0]          cw;
    logic                 tile_ok;
    logic                 child_ok;

    logic                 te_we;
    logic                 to_we;
    logic                 ce_we;
    logic                 co_we;
    logic                 c_we;
    logic [TB_AW-1:0]     t_waddr;
    logic [CB_AW-1:0]     c_waddr;
    logic [BYTE_W-1:0]    wdata;
    logic [TB_AW-1:0]     even_raddr;
    logic [TB_AW-1:0]     odd_raddr;
    logic [CB_AW-1:0]     c_raddr;

    logic [BYTE_W-1:0]    te_q;
    logic [BYTE_W-1:0]    to_q;
    logic [BYTE_W-1:0]    ce_q;
    logic [BYTE_W-1:0]    co_q;
    logic [BYTE_W-1:0]    c_q;
    logic [BYTE_W-1:0]    t_lo;
    logic [BYTE_W-1:0]    t_hi;
    logic [BYTE_W-1:0]    k_lo;
    logic [BYTE_W-1:0]    k_hi;
    logic [MASK_W-1:0]    tile4;
    logic [MASK_W-1:0]    cont4;
    logic [MASK_W-1:0]    child4;

    assign out_free = !out_valid_reg || !out_stall;
    assign pop      = q_valid && !clearing_reg && (!r_valid_reg || out_free);
    assign wr       = pop && q_ctrl.is_write;
    assign rd       = pop && !q_ctrl.is_write;
    assign clearing = clearing_reg;

    // clearing pass
    always_comb
    begin
        clearing_next = clearing_reg;
        clr_next      = clr_reg;
        if (clearing_reg)
        begin
            if (clr_reg == CLR_W'(CLR_N - 1))
            begin
                clearing_next = 1'b0;
            end
            else
            begin
                clr_next = clr_reg + CLR_W'(1);
            end
        end
    end

    // write and read addressing
    always_comb
    begin
        qa         = 32'(q_addr);
        pw         = 32'(q_pos);
        cw         = 32'(clr_reg);
        tile_ok    = qa < 32'(TB);
        child_ok   = qa < 32'(CB);
        te_we      = 1'b0;
        to_we      = 1'b0;
        ce_we      = 1'b0;
        co_we      = 1'b0;
        c_we       = 1'b0;
        t_waddr    = TB_AW'(qa >> 1);
        c_waddr    = CB_AW'(qa);
        wdata      = q_val;
        even_raddr = TB_AW'((pw >> 4) + 32'(pw[3]));
        odd_raddr  = TB_AW'(pw >> 4);
        c_raddr    = CB_AW'(pw >> 3);
        if (clearing_reg)
        begin
            te_we   = cw < 32'(TBANK);
            to_we   = te_we;
            ce_we   = te_we;
            co_we   = te_we;
            c_we    = cw < 32'(CBANK);
            t_waddr = TB_AW'(clr_reg);
            c_waddr = CB_AW'(clr_reg);
            wdata   = '0;
        end
        else if (wr)
        begin
            unique case (q_ctrl.sel)
                SEL_TILE:
                begin
                    te_we = tile_ok && !q_addr[0];
                    to_we = tile_ok && q_addr[0];
                end
                SEL_CONTENT:
                begin
                    ce_we = tile_ok && !q_addr[0];
                    co_we = tile_ok && q_addr[0];
                end
                SEL_CHILD:
                begin
                    c_we = child_ok;
                end
                default:
                begin
                end
            endcase
        end
    end

    iqca_ram #(.WIDTH(BYTE_W), .DEPTH(TBANK), .ADDR_W(TB_AW)) u_tile_even (
        .clk   (clk),
        .we    (te_we),
        .waddr (t_waddr),
        .wdata (wdata),
        .re    (rd),
        .raddr (even_raddr),
        .rdata (te_q)
    );

    iqca_ram #(.WIDTH(BYTE_W), .DEPTH(TBANK), .ADDR_W(TB_AW)) u_tile_odd (
        .clk   (clk),
        .we    (to_we),
        .waddr (t_waddr),
        .wdata (wdata),
        .re    (rd),
        .raddr (odd_raddr),
        .rdata (to_q)
    );

    iqca_ram #(.WIDTH(BYTE_W), .DEPTH(TBANK), .ADDR_W(TB_AW)) u_cont_even (
        .clk   (clk),
        .we    (ce_we),
        .waddr (t_waddr),
        .wdata (wdata),
        .re    (rd),
        .raddr (even_raddr),
        .rdata (ce_q)
    );

    iqca_ram #(.WIDTH(BYTE_W), .DEPTH(TBANK), .ADDR_W(TB_AW)) u_cont_odd (
        .clk   (clk),
        .we    (co_we),
        .waddr (t_waddr),
        .wdata (wdata),
        .re    (rd),
        .raddr (odd_raddr),
        .rdata (co_q)
    );

    iqca_ram #(.WIDTH(BYTE_W), .DEPTH(CBANK), .ADDR_W(CB_AW)) u_child (
        .clk   (clk),
        .we    (c_we),
        .waddr (c_waddr),
        .wdata (wdata),
        .re    (rd),
        .raddr (c_raddr),
        .rdata (c_q)
    );

    // read stage control
    always_comb
    begin
        r_valid_next = r_valid_reg;
        if (pop)
        begin
            r_valid_next = 1'b1;
        end
        else if (out_free)
        begin
            r_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (out_free)
        begin
            out_valid_next = r_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg  <= 1'b1;
            clr_reg       <= '0;
            r_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            clearing_reg  <= clearing_next;
            clr_reg       <= clr_next;
            r_valid_reg   <= r_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            r_ctrl_reg <= q_ctrl;
            r_b0_reg   <= q_pos[0] ^ q_pos[0] ^ pw[3];
            r_b2_reg   <= pw[2];
        end
    end

    // four tile/content child bits start at bit 1 or 5, the latter runs into the next byte
    always_comb
    begin
        t_lo   = r_b0_reg ? to_q : te_q;
        t_hi   = r_b0_reg ? te_q : to_q;
        k_lo   = r_b0_reg ? co_q : ce_q;
        k_hi   = r_b0_reg ? ce_q : co_q;
        tile4  = r_b2_reg ? {t_hi[0], t_lo[7:5]} : t_lo[4:1];
        cont4  = r_b2_reg ? {k_hi[0], k_lo[7:5]} : k_lo[4:1];
        child4 = r_b2_reg ? c_q[7:4] : c_q[3:0];
    end

    always_comb
    begin
        status_next  = 1'b0;
        hit_next     = 1'b0;
        present_next = '0;
        content_next = '0;
        if (!r_ctrl_reg.is_write)
        begin
            hit_next = r_ctrl_reg.hit;
            if (r_ctrl_reg.hit)
            begin
                if (r_ctrl_reg.interior)
                begin
                    present_next = tile4;
                    content_next = cont4;
                end
                else
                begin
                    present_next = child4;
                end
            end
            priority if (r_ctrl_reg.beyond)
            begin
                status_next = 1'b0;
            end
            else if (!r_ctrl_reg.hit)
            begin
                status_next = 1'b1;
            end
            else if (r_ctrl_reg.interior)
            begin
                status_next = 1'b0;
            end
            else
            begin
                status_next = |child4;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free && r_valid_reg)
        begin
            status_reg  <= status_next;
            hit_reg     <= hit_next;
            present_reg <= present_next;
            content_reg <= content_next;
        end
    end

    assign out_valid       = out_valid_reg;
    assign children_status = status_reg;
    assign subtree_hit     = hit_reg;
    assign child_present   = present_reg;
    assign child_content   = content_reg;

    a_no_pop_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
        clearing_reg |-> !pop && !r_valid_reg)
        else $error("request issued during clearing pass");

    a_miss_masks_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !hit_reg |-> present_reg == '0 && content_reg == '0)
        else $error("child masks reported on subtree miss");

endmodule
